// File: hdl/wdss_pkg.sv
// wdss_pkg: shared constants and saturating arithmetic for the stump search
// depends on nothing; imported by wdss_ram users and the top level
package wdss_pkg;

  localparam int SumW = 40;
  localparam int ValW = 32;
  localparam int WgtW = 32;
  localparam int RowW = ValW + WgtW + 2;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  localparam logic [1:0] DirPos  = 2'b01;
  localparam logic [1:0] DirNeg  = 2'b11;
  localparam logic [1:0] DirNone = 2'b00;

  typedef logic [SumW-1:0] sum_t;

  // row memory word: missing flag, positive flag, weight, value
  typedef struct packed {
    logic            miss;
    logic            pos;
    logic [WgtW-1:0] wgt;
    logic [ValW-1:0] val;
  } row_t;

  typedef struct packed {
    sum_t pos;
    sum_t neg;
  } cat_sums_t;

  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? SumMax : s[SumW-1:0];
  endfunction

  function automatic sum_t floor_sub(input sum_t a, input sum_t b);
    return (a > b) ? a - b : '0;
  endfunction

endpackage

// File: hdl/wdss_ram.sv
// wdss_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies
module wdss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/weighted_decision_stump_search.sv
// weighted_decision_stump_search: top level, sample intake, column sweep and best stump
// depends on wdss_pkg and wdss_ram
//
//  channel | ports                               | handshake
//  input   | start, busy, in_*                   | taken when start && !busy
//  result  | out_valid, out_best_*, out_all_done | one cycle strobe, no backpressure
//
// a sample is taken in S_IDLE, which reads the category sum entry; S_UPD writes it back.
// column end adds the sweep: continuous with two rows or more S_SW_RD/S_SW_DAT per row
// read, S_SW_GA/S_SW_GB per distinct-value boundary, then S_FIN; categorical
// S_CT_RD/S_CT_ACC per category, S_CT_FIN, S_FIN; skip column or a continuous column
// of one row S_FIN. the strobe is high in the cycle after S_FIN, when busy is low again.
// reset is synchronous, active low; the row memories need no clearing, category
// entries carry valid bits that clear at every column end.
// busy stays high from the taken sample until its column work is over.
module weighted_decision_stump_search #(
  parameter int MAX_ROWS       = 1024,
  parameter int MAX_CATEGORIES = 32,
  parameter int MAX_COLUMNS    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_column_number,
  input  logic [5:0]         in_category_count,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_value_missing,
  input  logic               in_positive_label,
  input  logic [31:0]        in_sample_weight,
  input  logic               in_column_end,
  input  logic               in_search_end,
  output logic               out_valid,
  output logic [7:0]         out_best_column,
  output logic signed [1:0]  out_best_direction,
  output logic               out_best_is_category,
  output logic signed [31:0] out_best_threshold,
  output logic [31:0]        out_best_category_set,
  output logic [39:0]        out_best_gain,
  output logic               out_all_done
);
  import wdss_pkg::*;

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CAW = $clog2(MAX_CATEGORIES);
  localparam int KW  = $clog2(MAX_CATEGORIES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_SW_RD, S_SW_DAT, S_SW_GA, S_SW_GB,
    S_CT_RD, S_CT_ACC, S_CT_FIN, S_FIN
  } state_t;

  state_t state_r;

  // column state
  logic            col_open_r;
  logic [7:0]      col_num_r;
  logic [KW-1:0]   kind_r;
  logic [KW-1:0]   cur_r;
  logic [ValW-1:0] prev_val_r;
  logic            prev_miss_r;
  logic [RW-1:0]   rows_r;
  sum_t            tot_pos_r, tot_neg_r, mh_r;
  logic [MAX_CATEGORIES-1:0] cat_vld_r;
  logic            cvld_r;

  // latched sample
  logic [WgtW-1:0] s_w_r;
  logic [ValW-1:0] s_val_r;
  logic            s_pos_r, s_miss_r, s_cend_r, s_send_r;

  // sweep state
  logic [RW-1:0]   idx_r;
  logic [KW-1:0]   k_r, nset_r;
  row_t            prv_r, cv_r;
  sum_t            pb_r, nb_r, pa_r, na_r, a_r, b_r;
  logic [ValW-1:0] mid_r;
  sum_t            fg_r;
  logic [1:0]      fdir_r;
  logic [ValW-1:0] fthr_r;
  logic [31:0]     fset_r;

  // best stump of the search
  logic [7:0]      best_col_r;
  logic [1:0]      best_dir_r;
  logic            best_cat_r;
  logic [ValW-1:0] best_thr_r;
  logic [31:0]     best_set_r;
  sum_t            best_gain_r;

  logic        out_valid_r;
  logic [7:0]  out_col_r;
  logic [1:0]  out_dir_r;
  logic        out_cat_r;
  logic [31:0] out_thr_r, out_set_r;
  sum_t        out_gain_r;
  logic        out_done_r;

  // memories
  logic      row_we;
  logic [AW-1:0] row_waddr, row_raddr;
  row_t      row_wdata, row_rdata;
  logic      cat_we;
  logic [CAW-1:0] cat_waddr, cat_raddr;
  cat_sums_t cat_wdata, cat_rdata, cat_old;

  wdss_ram #(.WIDTH(RowW), .DEPTH(MAX_ROWS)) u_rows (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  wdss_ram #(.WIDTH(2 * SumW), .DEPTH(MAX_CATEGORIES)) u_cats (
    .clk(clk), .we(cat_we), .waddr(cat_waddr), .wdata(cat_wdata),
    .raddr(cat_raddr), .rdata(cat_rdata)
  );

  // constant lookup of the column number modulo MAX_COLUMNS
  function automatic logic [7:0] col_reduce(input logic [7:0] c);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (c == 8'(i)) begin
        r = 8'(i % MAX_COLUMNS);
      end
    end
    return r;
  endfunction

  // intake decode
  logic          acc, first;
  logic [KW-1:0] kind_in, cur_nxt;
  logic [RW-1:0] rows_nxt, idx_nxt;
  logic [KW-1:0] k_nxt;
  sum_t          w40, g, fg_cat;
  sum_t          tot_pos_nxt, tot_neg_nxt;
  logic [32:0]   mid_sum;
  logic [4:0]    kbit;

  assign acc   = start && (state_r == S_IDLE);
  assign busy  = (state_r != S_IDLE);
  assign first = !col_open_r;
  assign w40   = SumW'(s_w_r);

  always_comb begin
    if (first) begin
      kind_in = (int'(in_category_count) > MAX_CATEGORIES) ? KW'(MAX_CATEGORIES)
                                                            : KW'(in_category_count);
    end else begin
      kind_in = kind_r;
    end
    cur_nxt = cur_r;
    if (!first && (cur_r < kind_in) &&
        (in_value_missing || prev_miss_r || (in_sample_value != prev_val_r))) begin
      cur_nxt = cur_r + 1'b1;
    end
  end

  assign rows_nxt = (rows_r < RW'(MAX_ROWS)) ? rows_r + 1'b1 : rows_r;
  assign idx_nxt  = idx_r + 1'b1;
  assign k_nxt    = k_r + 1'b1;
  assign kbit     = 5'(k_r);
  assign cat_old  = cvld_r ? cat_rdata : '0;
  assign g        = sat_add((a_r > b_r) ? a_r : b_r, mh_r);
  assign mid_sum  = {prv_r.val[ValW-1], prv_r.val} + {cv_r.val[ValW-1], cv_r.val};
  assign fg_cat   = sat_add(fg_r, mh_r);

  // totals including the sample in the update cycle
  assign tot_pos_nxt = ((kind_r == '0) && (rows_r < RW'(MAX_ROWS)) && !s_miss_r && s_pos_r)
                       ? sat_add(tot_pos_r, w40) : tot_pos_r;
  assign tot_neg_nxt = ((kind_r == '0) && (rows_r < RW'(MAX_ROWS)) && !s_miss_r && !s_pos_r)
                       ? sat_add(tot_neg_r, w40) : tot_neg_r;

  always_comb begin
    row_we    = (state_r == S_UPD) && (kind_r == '0) && (rows_r < RW'(MAX_ROWS));
    row_waddr = rows_r[AW-1:0];
    row_wdata = '{miss: s_miss_r, pos: s_pos_r, wgt: s_w_r, val: s_val_r};
    row_raddr = idx_r[AW-1:0];
    cat_we    = (state_r == S_UPD) && (kind_r >= KW'(2)) && (cur_r < kind_r);
    cat_waddr = cur_r[CAW-1:0];
    cat_wdata = cat_old;
    if (s_pos_r) begin
      cat_wdata.pos = sat_add(cat_old.pos, w40);
    end else begin
      cat_wdata.neg = sat_add(cat_old.neg, w40);
    end
    cat_raddr = (state_r == S_IDLE) ? cur_nxt[CAW-1:0] : k_r[CAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_open_r  <= 1'b0;
      col_num_r   <= '0;
      kind_r      <= '0;
      cur_r       <= '0;
      prev_val_r  <= '0;
      prev_miss_r <= 1'b0;
      rows_r      <= '0;
      tot_pos_r   <= '0;
      tot_neg_r   <= '0;
      mh_r        <= '0;
      cat_vld_r   <= '0;
      fg_r        <= '0;
      fdir_r      <= DirNone;
      fthr_r      <= '0;
      fset_r      <= '0;
      nset_r      <= '0;
      best_col_r  <= '0;
      best_dir_r  <= DirNone;
      best_cat_r  <= 1'b0;
      best_thr_r  <= '0;
      best_set_r  <= '0;
      best_gain_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            s_w_r      <= in_sample_weight;
            s_val_r    <= in_sample_value;
            s_pos_r    <= in_positive_label;
            s_miss_r   <= in_value_missing;
            s_cend_r   <= in_column_end;
            s_send_r   <= in_search_end;
            col_open_r <= 1'b1;
            kind_r     <= kind_in;
            if (first) begin
              col_num_r <= col_reduce(in_column_number);
            end
            if (kind_in >= KW'(2)) begin
              cur_r       <= cur_nxt;
              prev_val_r  <= in_sample_value;
              prev_miss_r <= in_value_missing;
            end
            cvld_r  <= cat_vld_r[cur_nxt[CAW-1:0]];
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (kind_r == '0) begin
            if (rows_r < RW'(MAX_ROWS)) begin
              rows_r <= rows_nxt;
              if (s_miss_r) begin
                mh_r <= sat_add(mh_r, w40 >> 1);
              end else if (s_pos_r) begin
                tot_pos_r <= sat_add(tot_pos_r, w40);
              end else begin
                tot_neg_r <= sat_add(tot_neg_r, w40);
              end
            end
          end else if (kind_r >= KW'(2)) begin
            if (cur_r >= kind_r) begin
              mh_r <= sat_add(mh_r, w40 >> 1);
            end else begin
              cat_vld_r[cur_r[CAW-1:0]] <= 1'b1;
            end
          end
          if (s_cend_r || s_send_r) begin
            idx_r <= '0;
            k_r   <= '0;
            pb_r  <= '0;
            nb_r  <= '0;
            pa_r  <= tot_pos_nxt;
            na_r  <= tot_neg_nxt;
            if (kind_r == '0) begin
              state_r <= (rows_nxt >= RW'(2)) ? S_SW_RD : S_FIN;
            end else if (kind_r >= KW'(2)) begin
              state_r <= S_CT_RD;
            end else begin
              state_r <= S_FIN;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SW_RD: state_r <= S_SW_DAT;
        S_SW_DAT: begin
          if (idx_r == '0) begin
            prv_r   <= row_rdata;
            idx_r   <= idx_nxt;
            state_r <= S_SW_RD;
          end else begin
            cv_r <= row_rdata;
            if (prv_r.pos) begin
              pb_r <= sat_add(pb_r, SumW'(prv_r.wgt));
              pa_r <= floor_sub(pa_r, SumW'(prv_r.wgt));
            end else begin
              nb_r <= sat_add(nb_r, SumW'(prv_r.wgt));
              na_r <= floor_sub(na_r, SumW'(prv_r.wgt));
            end
            if (row_rdata.miss) begin
              state_r <= S_FIN;
            end else if (prv_r.miss || (prv_r.val != row_rdata.val)) begin
              state_r <= S_SW_GA;
            end else begin
              prv_r   <= row_rdata;
              idx_r   <= idx_nxt;
              state_r <= (idx_nxt == rows_r) ? S_FIN : S_SW_RD;
            end
          end
        end
        S_SW_GA: begin
          a_r     <= sat_add(pa_r, nb_r);
          b_r     <= sat_add(na_r, pb_r);
          mid_r   <= mid_sum[32:1];
          state_r <= S_SW_GB;
        end
        S_SW_GB: begin
          if (g > fg_r) begin
            fg_r   <= g;
            fdir_r <= (a_r > b_r) ? DirPos : DirNeg;
            fthr_r <= mid_r;
          end
          prv_r   <= cv_r;
          idx_r   <= idx_nxt;
          state_r <= (idx_nxt == rows_r) ? S_FIN : S_SW_RD;
        end
        S_CT_RD: begin
          cvld_r  <= cat_vld_r[k_r[CAW-1:0]];
          state_r <= S_CT_ACC;
        end
        S_CT_ACC: begin
          if (cat_old.pos > cat_old.neg) begin
            fg_r   <= sat_add(fg_r, cat_old.pos);
            nset_r <= nset_r + 1'b1;
            if (int'(k_r) < 32) begin
              fset_r[kbit] <= 1'b1;
            end
          end else begin
            fg_r <= sat_add(fg_r, cat_old.neg);
          end
          k_r     <= k_nxt;
          state_r <= (k_nxt == kind_r) ? S_CT_FIN : S_CT_RD;
        end
        S_CT_FIN: begin
          // a set holding no category or every category is a trivial split
          fg_r    <= ((nset_r == '0) || (nset_r == kind_r)) ? '0 : fg_cat;
          fdir_r  <= DirPos;
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_done_r  <= s_send_r;
          if (fg_r > best_gain_r) begin
            out_col_r  <= col_num_r;
            out_dir_r  <= fdir_r;
            out_cat_r  <= (kind_r >= KW'(2));
            out_thr_r  <= fthr_r;
            out_set_r  <= fset_r;
            out_gain_r <= fg_r;
          end else begin
            out_col_r  <= best_col_r;
            out_dir_r  <= best_dir_r;
            out_cat_r  <= best_cat_r;
            out_thr_r  <= best_thr_r;
            out_set_r  <= best_set_r;
            out_gain_r <= best_gain_r;
          end
          if (s_send_r) begin
            best_col_r  <= '0;
            best_dir_r  <= DirNone;
            best_cat_r  <= 1'b0;
            best_thr_r  <= '0;
            best_set_r  <= '0;
            best_gain_r <= '0;
          end else if (fg_r > best_gain_r) begin
            best_col_r  <= col_num_r;
            best_dir_r  <= fdir_r;
            best_cat_r  <= (kind_r >= KW'(2));
            best_thr_r  <= fthr_r;
            best_set_r  <= fset_r;
            best_gain_r <= fg_r;
          end
          col_open_r  <= 1'b0;
          col_num_r   <= '0;
          kind_r      <= '0;
          cur_r       <= '0;
          prev_val_r  <= '0;
          prev_miss_r <= 1'b0;
          rows_r      <= '0;
          tot_pos_r   <= '0;
          tot_neg_r   <= '0;
          mh_r        <= '0;
          cat_vld_r   <= '0;
          fg_r        <= '0;
          fdir_r      <= DirNone;
          fthr_r      <= '0;
          fset_r      <= '0;
          nset_r      <= '0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_best_column       = out_col_r;
  assign out_best_direction    = out_dir_r;
  assign out_best_is_category  = out_cat_r;
  assign out_best_threshold    = out_thr_r;
  assign out_best_category_set = out_set_r;
  assign out_best_gain         = out_gain_r;
  assign out_all_done          = out_done_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after taking a sample");

  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= RW'(MAX_ROWS))
    else $error("row count past buffer depth");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= kind_r)
    else $error("category cursor past category count");

endmodule

// File: tb/weighted_decision_stump_search_tb.sv
// weighted_decision_stump_search_tb: self-checking regression for the stump search block
// depends on wdss_pkg (direction codes, sum type) and weighted_decision_stump_search
`timescale 1ns / 100ps

module weighted_decision_stump_search_tb;
  import wdss_pkg::*;

  localparam int NumRows   = 1024;
  localparam int NumCats   = 32;
  localparam int IdleLimit = 40000;

  typedef struct {
    logic [7:0]  column;
    logic [1:0]  direction;
    logic        is_category;
    logic [31:0] threshold;
    logic [31:0] category_set;
    sum_t        gain;
    logic        all_done;
  } stump_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_column_number = '0;
  logic [5:0] in_category_count = '0;
  logic signed [31:0] in_sample_value = '0;
  logic in_value_missing = 1'b0;
  logic in_positive_label = 1'b0;
  logic [31:0] in_sample_weight = '0;
  logic in_column_end = 1'b0;
  logic in_search_end = 1'b0;
  logic out_valid;
  logic [7:0] out_best_column;
  logic signed [1:0] out_best_direction;
  logic out_best_is_category;
  logic signed [31:0] out_best_threshold;
  logic [31:0] out_best_category_set;
  logic [39:0] out_best_gain;
  logic out_all_done;

  weighted_decision_stump_search dut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] buf_value [NumRows];
  logic [31:0] buf_weight [NumRows];
  logic        buf_pos [NumRows];
  logic        buf_miss [NumRows];
  int          buf_count;
  sum_t        cat_pos [NumCats];
  sum_t        cat_neg [NumCats];
  int          cat_cursor;
  sum_t        sum_pos, sum_neg, sum_missing_half;
  logic        column_open;
  logic [7:0]  column_id;
  int          column_kind;
  logic [31:0] last_value;
  logic        last_missing;
  stump_t      best_stump;

  stump_t expected_stumps[$];
  int     error_count = 0;
  int     items_sent = 0;
  int     idle_cycles = 0;
  bit     gaps_on = 1'b1;

  function automatic sum_t add_clip(sum_t a, sum_t b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? SumMax : s[39:0];
  endfunction

  function automatic sum_t sub_floor(sum_t a, sum_t b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic open_column_state();
    buf_count = 0;
    for (int k = 0; k < NumCats; k++) begin
      cat_pos[k] = '0;
      cat_neg[k] = '0;
    end
    cat_cursor = 0;
    sum_pos = '0;
    sum_neg = '0;
    sum_missing_half = '0;
    column_open = 1'b0;
    column_id = '0;
    column_kind = 0;
    last_value = '0;
    last_missing = 1'b0;
  endtask

  task automatic clear_best_stump();
    best_stump = '{8'd0, DirNone, 1'b0, 32'd0, 32'd0, '0, 1'b0};
  endtask

  // works out the stump emitted (if any) for one accepted sample
  task automatic predict_stump(logic [7:0] col, logic [5:0] cnt, logic [31:0] val,
                               logic miss, logic pos, logic [31:0] w,
                               logic cend, logic send);
    bit first;
    sum_t g, pb, nb, pa, na, a, b, cg;
    logic [1:0] dir;
    logic [31:0] thr, cset;
    logic [32:0] s;
    bit is_cat;
    int nset;
    first = 1'b0;
    if (!column_open) begin
      column_open = 1'b1;
      first = 1'b1;
      column_id = col;
      column_kind = (cnt > NumCats) ? NumCats : cnt;
    end
    if (column_kind == 0) begin
      if (buf_count < NumRows) begin
        buf_value[buf_count] = val;
        buf_weight[buf_count] = w;
        buf_pos[buf_count] = pos;
        buf_miss[buf_count] = miss;
        buf_count++;
        if (miss) sum_missing_half = add_clip(sum_missing_half, {9'd0, w[31:1]});
        else if (pos) sum_pos = add_clip(sum_pos, {8'd0, w});
        else sum_neg = add_clip(sum_neg, {8'd0, w});
      end
    end else if (column_kind >= 2) begin
      if (!first && cat_cursor < column_kind && (miss || last_missing || val != last_value))
        cat_cursor++;
      if (cat_cursor >= column_kind)
        sum_missing_half = add_clip(sum_missing_half, {9'd0, w[31:1]});
      else if (pos)
        cat_pos[cat_cursor] = add_clip(cat_pos[cat_cursor], {8'd0, w});
      else
        cat_neg[cat_cursor] = add_clip(cat_neg[cat_cursor], {8'd0, w});
      last_value = val;
      last_missing = miss;
    end
    if (!(cend || send)) return;

    g = '0;
    dir = DirNone;
    thr = '0;
    cset = '0;
    is_cat = 1'b0;
    if (column_kind == 0) begin
      pb = '0;
      nb = '0;
      pa = sum_pos;
      na = sum_neg;
      for (int i = 1; i < buf_count; i++) begin
        if (buf_pos[i-1]) begin
          pb = add_clip(pb, {8'd0, buf_weight[i-1]});
          pa = sub_floor(pa, {8'd0, buf_weight[i-1]});
        end else begin
          nb = add_clip(nb, {8'd0, buf_weight[i-1]});
          na = sub_floor(na, {8'd0, buf_weight[i-1]});
        end
        if (buf_miss[i]) break;
        if (buf_miss[i-1] || buf_value[i-1] != buf_value[i]) begin
          a = add_clip(pa, nb);
          b = add_clip(na, pb);
          cg = add_clip((a > b) ? a : b, sum_missing_half);
          if (cg > g) begin
            // midpoint in offset-binary so the floor works on signed values
            s = {1'b0, buf_value[i-1] ^ 32'h8000_0000} + {1'b0, buf_value[i] ^ 32'h8000_0000};
            g = cg;
            dir = (a > b) ? DirPos : DirNeg;
            thr = s[32:1] ^ 32'h8000_0000;
          end
        end
      end
    end else if (column_kind >= 2) begin
      nset = 0;
      is_cat = 1'b1;
      dir = DirPos;
      for (int k = 0; k < column_kind; k++) begin
        if (cat_pos[k] > cat_neg[k]) begin
          g = add_clip(g, cat_pos[k]);
          cset[k] = 1'b1;
          nset++;
        end else begin
          g = add_clip(g, cat_neg[k]);
        end
      end
      g = add_clip(g, sum_missing_half);
      if (nset == 0 || nset == column_kind) g = '0;
    end

    if (g > best_stump.gain) begin
      best_stump.gain = g;
      best_stump.column = column_id;
      best_stump.direction = dir;
      best_stump.is_category = is_cat;
      best_stump.threshold = is_cat ? 32'd0 : thr;
      best_stump.category_set = is_cat ? cset : 32'd0;
    end
    best_stump.all_done = send;
    expected_stumps.insert(expected_stumps.size(), best_stump);
    open_column_state();
    if (send) clear_best_stump();
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    stump_t e;
    if (rst_n && out_valid) begin
      if (expected_stumps.size() == 0) begin
        report_mismatch("unexpected result", 64'd1, 64'd0);
      end else begin
        e = expected_stumps.pop_front();
        if (out_best_column !== e.column) report_mismatch("column", out_best_column, e.column);
        if (out_best_direction !== e.direction)
          report_mismatch("direction", out_best_direction, e.direction);
        if (out_best_is_category !== e.is_category)
          report_mismatch("is_category", out_best_is_category, e.is_category);
        if (out_best_threshold !== e.threshold)
          report_mismatch("threshold", out_best_threshold, e.threshold);
        if (out_best_category_set !== e.category_set)
          report_mismatch("category_set", out_best_category_set, e.category_set);
        if (out_best_gain !== e.gain) report_mismatch("gain", out_best_gain, e.gain);
        if (out_all_done !== e.all_done)
          report_mismatch("all_done", out_all_done, e.all_done);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("weighted_decision_stump_search regression: fail");
      $finish;
    end
  end

  task automatic send_sample(logic [7:0] col, logic [5:0] cnt, logic [31:0] val,
                             logic miss, logic pos, logic [31:0] w,
                             logic cend, logic send);
    @(negedge clk);
    start <= 1'b1;
    in_column_number <= col;
    in_category_count <= cnt;
    in_sample_value <= val;
    in_value_missing <= miss;
    in_positive_label <= pos;
    in_sample_weight <= w;
    in_column_end <= cend;
    in_search_end <= send;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    items_sent++;
    predict_stump(col, cnt, val, miss, pos, w, cend, send);
  endtask

  task automatic maybe_gap();
    int n;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  function automatic logic [31:0] pick_weight(int mode);
    case (mode)
      1: return 32'hFFFF_FFFF;
      2: case ($urandom_range(0, 3))
           0: return 32'd0;
           1: return 32'hFFFF_FFFF;
           2: return $urandom_range(0, 15);
           default: return $urandom;
         endcase
      default: return $urandom;
    endcase
  endfunction

  // one column: sorted values with repeats, missing rows last
  // ending: 0 column_end, 1 column_end and search_end, 2 search_end alone
  task automatic send_column(logic [7:0] col, logic [5:0] cnt, int rows, int nmiss,
                             int wmode, int pos_pct, int ending);
    logic [31:0] v;
    logic [5:0] c;
    logic miss, last;
    v = $urandom;
    for (int r = 0; r < rows; r++) begin
      last = (r == rows - 1);
      miss = (r >= rows - nmiss);
      if (r > 0 && $urandom_range(0, 2) != 0)
        v = v + (($urandom_range(0, 1) == 0) ? $urandom_range(1, 9) : $urandom_range(1, 1 << 20));
      c = (r == 0) ? cnt : 6'($urandom);
      send_sample(col, c, miss ? 32'($urandom) : v, miss,
                  ($urandom_range(1, 100) <= pos_pct), pick_weight(wmode),
                  last && ending != 2, last && ending != 0);
      maybe_gap();
    end
  endtask

  task automatic test_continuous();
    send_column(8'd0, 6'd0, 1, 0, 0, 50, 0);
    send_column(8'd3, 6'd0, 6, 1, 2, 50, 0);
    send_sample(8'd4, 6'd0, 32'h8000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(8'd4, 6'd5, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0);
  endtask

  task automatic test_categorical();
    send_column(8'd255, 6'd2, 5, 1, 2, 60, 0);
    send_column(8'd7, 6'd63, 6, 0, 0, 50, 0);
  endtask

  task automatic test_skip_and_search_end();
    send_sample(8'd9, 6'd1, 32'd5, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_column(8'd10, 6'd3, 4, 0, 0, 50, 2);
    send_column(8'd11, 6'd0, 2, 0, 1, 50, 1);
  endtask

  task automatic test_random();
    int cnt_sel, rows, ending;
    logic [5:0] cnt;
    bit big_done;
    big_done = 1'b0;
    while (items_sent < 1800) begin
      gaps_on = (items_sent < 1500) && ($urandom_range(0, 3) != 0);
      cnt_sel = $urandom_range(0, 99);
      if (cnt_sel < 45) cnt = 6'd0;
      else if (cnt_sel < 85) cnt = 6'($urandom_range(2, 32));
      else if (cnt_sel < 92) cnt = 6'd1;
      else cnt = 6'($urandom_range(33, 63));
      rows = $urandom_range(1, 20);
      ending = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
      if (!big_done && items_sent > 600) begin
        // row overflow and 40-bit saturation in one long column
        big_done = 1'b1;
        send_column(8'($urandom), 6'd0, NumRows + 6, 3, 1, 50, 0);
        send_column(8'($urandom), 6'd2, 300, 0, 1, 100, 0);
      end else begin
        send_column(8'($urandom), cnt, rows, $urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0,
                    $urandom_range(0, 2), $urandom_range(0, 100), ending);
      end
    end
  endtask

  initial begin
    open_column_state();
    clear_best_stump();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_continuous();
    test_categorical();
    test_skip_and_search_end();
    test_random();
    @(negedge clk);
    start <= 1'b0;
    wait (expected_stumps.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("weighted_decision_stump_search regression: pass");
    else $display("weighted_decision_stump_search regression: fail");
    $finish;
  end

endmodule
